// ===== sv/assert_macros.svh =====
// Assertion macros shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BRE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define BRE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/bre_pkg.sv =====
// Types and constants of the run/mark entry encoder.
`default_nettype none

package bre_pkg;

  localparam int unsigned SYM_W           = 24;
  localparam int unsigned OFF_W           = 64;
  localparam int unsigned CHUNK_W         = 64;
  localparam int unsigned CHUNK_BITS_W    = 7;
  localparam int unsigned MAX_SYMBOL_BITS = 24;
  localparam int unsigned RUN_LEN_W       = 63;  // widest run counter supported
  localparam int unsigned RUN_LOG_W       = 6;
  localparam int unsigned QUEUE_DEPTH     = 2;   // power of two
  localparam int unsigned APB_ADDR_W      = 4;
  localparam int unsigned APB_DATA_W      = 32;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SYMBOL_BITS = 2'd0;
  localparam cfg_idx_t CFG_OFFSET_BITS = 2'd1;
  localparam cfg_idx_t CFG_END_SYMBOL  = 2'd2;

  localparam logic [4:0]       RST_SYMBOL_BITS = 5'd8;
  localparam logic [6:0]       RST_OFFSET_BITS = 7'd32;
  localparam logic [SYM_W-1:0] RST_END_SYMBOL  = 24'd255;

  typedef struct packed {
    logic [4:0]       symbol_bits;
    logic [6:0]       offset_bits;
    logic [SYM_W-1:0] end_symbol;
  } cfg_t;

  // What follows the optional closing run of an entry.
  typedef enum logic [1:0] {
    KIND_RUN,
    KIND_MARK,
    KIND_FINISH
  } kind_e;

  // Chunk currently produced by the back end; ST_START means "entry not begun".
  typedef enum logic [3:0] {
    ST_START,
    ST_RUN_HDR,
    ST_RUN_ZERO,
    ST_RUN_VAL,
    ST_MARK_HDR,
    ST_MARK_OFF,
    ST_END_HDR,
    ST_END_VAL,
    ST_PAD
  } step_e;

  typedef struct packed {
    logic                 has_run;
    kind_e                kind;
    logic [SYM_W-1:0]     run_sym;
    logic [RUN_LEN_W-1:0] run_len;
    logic [RUN_LOG_W-1:0] run_log;   // floor(log2(run_len))
    logic [SYM_W-1:0]     mark_sym;
    logic [OFF_W-1:0]     offset;
  } entry_t;

endpackage

`default_nettype wire

// ===== sv/bre_sym_if.sv =====
// Input channel: one transform symbol per item.
`default_nettype none

interface bre_sym_if;
  logic                       valid;
  logic                       ready;
  logic [bre_pkg::SYM_W-1:0]  symbol;
  logic                       has_mark;
  logic [bre_pkg::OFF_W-1:0]  mark_offset;
  logic                       finish;

  modport source (output valid, symbol, has_mark, mark_offset, finish, input ready);
  modport sink   (input valid, symbol, has_mark, mark_offset, finish, output ready);
endinterface

`default_nettype wire

// ===== sv/bre_chunk_if.sv =====
// Output channel: one bit chunk per item.
`default_nettype none

interface bre_chunk_if;
  logic                              valid;
  logic                              ready;
  logic [bre_pkg::CHUNK_W-1:0]       chunk_value;
  logic [bre_pkg::CHUNK_BITS_W-1:0]  chunk_bits;
  logic                              last_chunk;

  modport source (output valid, chunk_value, chunk_bits, last_chunk, input ready);
  modport sink   (input valid, chunk_value, chunk_bits, last_chunk, output ready);
endinterface

`default_nettype wire

// ===== sv/bre_front.sv =====
// Front end: run tracking and entry classification.
`default_nettype none

module bre_front #(
  parameter int unsigned RUN_BITS = 40
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  bre_sym_if.sink             sym_i,
  input  wire logic           full_i,
  output logic                push_o,
  output bre_pkg::entry_t     entry_o
);

  localparam int unsigned LogW = $clog2(RUN_BITS);
  localparam logic [RUN_BITS-1:0] RunMax = '1;
  localparam logic [RUN_BITS-1:0] RunOne = RUN_BITS'(1);

  logic [bre_pkg::SYM_W-1:0] sym_q, sym_d;
  logic                      held_q, held_d;
  logic [RUN_BITS-1:0]       cnt_q, cnt_d, cnt_inc;
  logic [LogW-1:0]           log_q, log_d;
  logic                      accept;

  assign sym_i.ready = !full_i;
  assign accept      = sym_i.valid && !full_i;
  assign cnt_inc     = cnt_q + RunOne;

  always_comb begin
    sym_d  = sym_q;
    held_d = held_q;
    cnt_d  = cnt_q;
    log_d  = log_q;
    push_o = 1'b0;

    entry_o.has_run  = held_q;
    entry_o.kind     = bre_pkg::KIND_RUN;
    entry_o.run_sym  = sym_q;
    entry_o.run_len  = bre_pkg::RUN_LEN_W'(cnt_q);
    entry_o.run_log  = bre_pkg::RUN_LOG_W'(log_q);
    entry_o.mark_sym = sym_i.symbol;
    entry_o.offset   = sym_i.mark_offset;

    if (accept) begin
      if (sym_i.finish || sym_i.has_mark) begin
        // finish wins over a mark; both close the held run
        push_o       = 1'b1;
        entry_o.kind = sym_i.finish ? bre_pkg::KIND_FINISH : bre_pkg::KIND_MARK;
        sym_d        = '0;
        held_d       = 1'b0;
        cnt_d        = '0;
        log_d        = '0;
      end else if (held_q && sym_i.symbol == sym_q) begin
        if (cnt_q == RunMax) begin
          // counter full: ship the saturated run, restart at one
          push_o = 1'b1;
          cnt_d  = RunOne;
          log_d  = '0;
        end else begin
          cnt_d = cnt_inc;
          // log2 steps up when the new count is a power of two
          if ((cnt_inc & cnt_q) == '0) begin
            log_d = log_q + LogW'(1);
          end
        end
      end else begin
        push_o = held_q;
        sym_d  = sym_i.symbol;
        held_d = 1'b1;
        cnt_d  = RunOne;
        log_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q  <= '0;
      held_q <= 1'b0;
      cnt_q  <= '0;
      log_q  <= '0;
    end else begin
      sym_q  <= sym_d;
      held_q <= held_d;
      cnt_q  <= cnt_d;
      log_q  <= log_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bre_queue.sv =====
// Entry queue between front and back end.
`default_nettype none

module bre_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire bre_pkg::entry_t  entry_i,
  output logic                  full_o,
  output logic                  valid_o,
  output bre_pkg::entry_t       head_o,
  input  wire logic             pop_i
);

  localparam int unsigned PtrW = $clog2(bre_pkg::QUEUE_DEPTH);

  bre_pkg::entry_t mem_q [bre_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = cnt_q == (PtrW + 1)'(bre_pkg::QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  // depth is a power of two, so the pointers wrap on their own
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PtrW + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PtrW + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/bre_back.sv =====
// Back end: chunk sequencer with output register.
`default_nettype none

module bre_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire bre_pkg::cfg_t    cfg_i,
  input  wire logic             head_valid_i,
  input  wire bre_pkg::entry_t  head_i,
  output logic                  pop_o,
  bre_chunk_if.source           chunk_o
);

  bre_pkg::step_e step_q, step_d, cur_step, nxt_step;

  logic [2:0]                          phase_q, phase_d;
  logic                                out_valid_q;
  logic [bre_pkg::CHUNK_W-1:0]         val_q, val_d;
  logic [bre_pkg::CHUNK_BITS_W-1:0]    bits_q, bits_d;
  logic                                last_q, last_d;
  logic                                advance;

  logic [4:0]                  sym_w;
  logic [6:0]                  off_w;
  logic [bre_pkg::SYM_W-1:0]   sym_mask, hdr_sym;
  logic [bre_pkg::OFF_W-1:0]   off_mask;
  logic                        hdr_flag;
  logic [bre_pkg::CHUNK_W-1:0] hdr_val;

  // clamp the coded widths
  always_comb begin
    if (cfg_i.symbol_bits == 5'd0) begin
      sym_w = 5'd1;
    end else if (cfg_i.symbol_bits > 5'(bre_pkg::MAX_SYMBOL_BITS)) begin
      sym_w = 5'(bre_pkg::MAX_SYMBOL_BITS);
    end else begin
      sym_w = cfg_i.symbol_bits;
    end
    if (cfg_i.offset_bits == 7'd0) begin
      off_w = 7'd1;
    end else if (cfg_i.offset_bits > 7'(bre_pkg::OFF_W)) begin
      off_w = 7'(bre_pkg::OFF_W);
    end else begin
      off_w = cfg_i.offset_bits;
    end
  end

  assign sym_mask = {bre_pkg::SYM_W{1'b1}} >> (5'(bre_pkg::SYM_W) - sym_w);
  assign off_mask = {bre_pkg::OFF_W{1'b1}} >> (7'(bre_pkg::OFF_W) - off_w);
  assign advance  = head_valid_i && (!out_valid_q || chunk_o.ready);

  always_comb begin
    if (step_q != bre_pkg::ST_START) begin
      cur_step = step_q;
    end else if (head_i.has_run) begin
      cur_step = bre_pkg::ST_RUN_HDR;
    end else if (head_i.kind == bre_pkg::KIND_MARK) begin
      cur_step = bre_pkg::ST_MARK_HDR;
    end else begin
      cur_step = bre_pkg::ST_END_HDR;
    end

    case (cur_step)
      bre_pkg::ST_MARK_HDR: begin
        hdr_sym  = head_i.mark_sym;
        hdr_flag = 1'b1;
      end
      bre_pkg::ST_END_HDR: begin
        hdr_sym  = cfg_i.end_symbol;
        hdr_flag = 1'b0;
      end
      default: begin
        hdr_sym  = head_i.run_sym;
        hdr_flag = 1'b0;
      end
    endcase
    hdr_val = {39'd0, hdr_sym & sym_mask, hdr_flag};

    val_d    = '0;
    bits_d   = 7'd1;
    nxt_step = bre_pkg::ST_START;
    case (cur_step)
      bre_pkg::ST_RUN_HDR: begin
        val_d    = hdr_val;
        bits_d   = {2'b00, sym_w} + 7'd1;
        nxt_step = (head_i.run_log != '0) ? bre_pkg::ST_RUN_ZERO : bre_pkg::ST_RUN_VAL;
      end
      bre_pkg::ST_RUN_ZERO: begin
        bits_d   = 7'(head_i.run_log);
        nxt_step = bre_pkg::ST_RUN_VAL;
      end
      bre_pkg::ST_RUN_VAL: begin
        val_d  = bre_pkg::CHUNK_W'(head_i.run_len);
        bits_d = 7'(head_i.run_log) + 7'd1;
        case (head_i.kind)
          bre_pkg::KIND_MARK:   nxt_step = bre_pkg::ST_MARK_HDR;
          bre_pkg::KIND_FINISH: nxt_step = bre_pkg::ST_END_HDR;
          default:              nxt_step = bre_pkg::ST_START;
        endcase
      end
      bre_pkg::ST_MARK_HDR: begin
        val_d    = hdr_val;
        bits_d   = {2'b00, sym_w} + 7'd1;
        nxt_step = bre_pkg::ST_MARK_OFF;
      end
      bre_pkg::ST_MARK_OFF: begin
        val_d  = head_i.offset & off_mask;
        bits_d = off_w;
      end
      bre_pkg::ST_END_HDR: begin
        val_d    = hdr_val;
        bits_d   = {2'b00, sym_w} + 7'd1;
        nxt_step = bre_pkg::ST_END_VAL;
      end
      bre_pkg::ST_END_VAL: begin
        // closing run of length one, then pad if off a byte boundary
        val_d    = bre_pkg::CHUNK_W'(1);
        nxt_step = (phase_q + 3'd1 != 3'd0) ? bre_pkg::ST_PAD : bre_pkg::ST_START;
      end
      bre_pkg::ST_PAD: begin
        bits_d = {3'b000, 4'd8 - {1'b0, phase_q}};
      end
      default: begin
        nxt_step = bre_pkg::ST_START;
      end
    endcase

    last_d  = nxt_step == bre_pkg::ST_START;
    pop_o   = advance && last_d;
    step_d  = advance ? nxt_step : step_q;
    phase_d = advance ? phase_q + bits_d[2:0] : phase_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= bre_pkg::ST_START;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      phase_q <= phase_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (chunk_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      val_q  <= val_d;
      bits_q <= bits_d;
      last_q <= last_d;
    end
  end

  assign chunk_o.valid       = out_valid_q;
  assign chunk_o.chunk_value = val_q;
  assign chunk_o.chunk_bits  = bits_q;
  assign chunk_o.last_chunk  = last_q;

endmodule

`default_nettype wire

// ===== sv/bwt_run_mark_encoder.sv =====
// Top level of the run/mark entry encoder.
//
//  channel   dir  handshake        payload
//  --------  ---  ---------------  ---------------------------------------------
//  sym_i     in   valid/ready      symbol, has_mark, mark_offset, finish
//  chunk_o   out  valid/ready      chunk_value, chunk_bits, last_chunk
//  APB       in   psel/penable     paddr, pwdata, pwrite -> prdata, pready
//
//  An item is taken every cycle while the two-entry queue has room; an item that
//  only extends a run is absorbed with no entry unless its counter is full. The
//  back end sends one chunk a cycle unless stalled: a run entry takes 2 or 3
//  chunks, a mark item up to 5, a finish up to 6. Reset is asynchronous, active
//  low, and clears run state, queue and bit phase. The output register lets the
//  sink stall without blocking the front end until the queue fills.
`include "assert_macros.svh"
`default_nettype none

module bwt_run_mark_encoder #(
  parameter int unsigned RUN_BITS = 40
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  bre_sym_if.sink                                sym_i,
  bre_chunk_if.source                            chunk_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bre_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [bre_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [bre_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready
);

  bre_pkg::cfg_t    cfg_q;
  bre_pkg::cfg_idx_t reg_idx;
  logic             cfg_wr;

  bre_pkg::entry_t  push_entry, head_entry;
  logic             push, pop, q_full, q_valid;

  // ---------------------------------------------------------------------------
  // Register port: pready tied high, registers at 4-byte strides
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.symbol_bits <= bre_pkg::RST_SYMBOL_BITS;
      cfg_q.offset_bits <= bre_pkg::RST_OFFSET_BITS;
      cfg_q.end_symbol  <= bre_pkg::RST_END_SYMBOL;
    end else if (cfg_wr) begin
      case (reg_idx)
        bre_pkg::CFG_SYMBOL_BITS: cfg_q.symbol_bits <= pwdata[4:0];
        bre_pkg::CFG_OFFSET_BITS: cfg_q.offset_bits <= pwdata[6:0];
        bre_pkg::CFG_END_SYMBOL:  cfg_q.end_symbol  <= pwdata[bre_pkg::SYM_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bre_pkg::CFG_SYMBOL_BITS: prdata = {27'd0, cfg_q.symbol_bits};
      bre_pkg::CFG_OFFSET_BITS: prdata = {25'd0, cfg_q.offset_bits};
      bre_pkg::CFG_END_SYMBOL:  prdata = {8'd0, cfg_q.end_symbol};
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Front end: holds the current run, turns each closing event into one entry
  // ---------------------------------------------------------------------------
  bre_front #(
    .RUN_BITS (RUN_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sym_i   (sym_i),
    .full_i  (q_full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // ---------------------------------------------------------------------------
  // Queue decouples run tracking from chunk emission
  // ---------------------------------------------------------------------------
  bre_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head_entry),
    .pop_i   (pop)
  );

  // ---------------------------------------------------------------------------
  // Back end: walks each entry chunk by chunk, tracks byte phase for padding
  // ---------------------------------------------------------------------------
  bre_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (q_valid),
    .head_i       (head_entry),
    .pop_o        (pop),
    .chunk_o      (chunk_o)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `BRE_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, q_full, !push)
  `BRE_ASSERT_IMP(a_finish_pushes, clk_i, rst_ni, sym_i.valid && sym_i.ready && sym_i.finish, push)
  `BRE_ASSERT_IMP(a_chunk_bits, clk_i, rst_ni, chunk_o.valid, chunk_o.chunk_bits != 7'd0 && chunk_o.chunk_bits <= 7'd64)
  `BRE_ASSERT_NXT(a_push_lands, clk_i, rst_ni, push && !pop, q_valid)

endmodule

`default_nettype wire
